// ===== rtl/core/flcm_pkg.sv =====
`default_nettype none

package flcm_pkg;

   // port count, default frame buffer depth and job queue depth
   localparam int NUM_PORTS        = 6;
   localparam int FRAME_DEPTH_DEF  = 16;
   localparam int JOB_QUEUE_DEPTH  = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_MASTER     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_MASK = 2'd2;

   // request commands
   localparam logic [1:0] CMD_GO_MAP  = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_END_MAP = 2'd2;
   localparam logic [1:0] CMD_START   = 2'd3;

   // response kinds
   localparam logic [2:0] K_GO_MAP  = 3'd0;
   localparam logic [2:0] K_FRAME   = 3'd1;
   localparam logic [2:0] K_END_MAP = 3'd2;
   localparam logic [2:0] K_ACK     = 3'd3;
   localparam logic [2:0] K_NACK    = 3'd4;
   localparam logic [2:0] K_DONE    = 3'd5;

   // one unit of work for the back end: go-map messages on the ports in
   // fwd_mask, then an optional tail message, then an optional end-map
   // to the tail's port
   typedef struct packed {
      logic [NUM_PORTS-1:0] fwd_mask;
      logic [15:0]          ident;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic signed [15:0]   z;
      logic                 t1;
      logic [2:0]           t1_kind;
      logic [2:0]           t1_port;
      logic                 t1_use_id;
      logic                 t1_use_xyz;
      logic                 t2;
   } job_type;

   // front to queue
   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/core/flcm_front.sv =====
`default_nettype none

module flcm_front #(
   parameter int FRAME_DEPTH = flcm_pkg::FRAME_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [2:0]                      req_in_port,
   input  wire logic [15:0]                     req_sender_id,
   input  wire logic signed [15:0]              req_coord_x,
   input  wire logic signed [15:0]              req_coord_y,
   input  wire logic signed [15:0]              req_coord_z,
   input  wire logic                            csr_we,
   input  wire logic [flcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [flcm_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            q_full,
   output flcm_pkg::push_type                   q_push
);

   localparam int FCW = $clog2(FRAME_DEPTH + 1);
   localparam int AW  = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int NP  = flcm_pkg::NUM_PORTS;

   function automatic logic [2:0] count_ports(input logic [NP-1:0] m);
      logic [2:0] c;
      c = 3'd0;
      for (int i = 0; i < NP; i++) begin
         c = c + 3'(m[i]);
      end
      return c;
   endfunction

   // configuration
   logic          is_master_ff;
   logic [15:0]   own_id_ff;
   logic [NP-1:0] nmask_ff;

   // node state
   logic                 joined_ff, joined_in;
   logic                 has_parent_ff, has_parent_in;
   logic [2:0]           parent_ff, parent_in;
   logic signed [15:0]   node_x_ff, node_x_in;
   logic signed [15:0]   node_y_ff, node_y_in;
   logic signed [15:0]   node_z_ff, node_z_in;
   logic [2:0]           pend_ff, pend_in;
   logic [FCW-1:0]       fc_ff, fc_in;

   // frame buffer, written only
   logic [63:0]   frame_store [FRAME_DEPTH];
   logic          store_we;

   logic          accept;
   logic [NP-1:0] port_onehot;
   logic          port_ok;
   logic [NP-1:0] fwd_join;
   logic [2:0]    cnt_start;
   logic [2:0]    cnt_join;
   flcm_pkg::job_type job;

   assign req_ready   = !q_full;
   assign accept      = req_valid && req_ready;
   assign port_onehot = NP'(1) << req_in_port;
   assign port_ok     = |(port_onehot & nmask_ff);
   assign fwd_join    = nmask_ff & ~port_onehot;
   assign cnt_start   = count_ports(nmask_ff);
   assign cnt_join    = count_ports(fwd_join);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         is_master_ff <= 1'b0;
         own_id_ff    <= 16'd0;
         nmask_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            flcm_pkg::CSR_IS_MASTER:     is_master_ff <= csr_wdata[0];
            flcm_pkg::CSR_OWN_ID:        own_id_ff    <= csr_wdata;
            flcm_pkg::CSR_NEIGHBOR_MASK: nmask_ff     <= csr_wdata[NP-1:0];
            default: ;
         endcase
      end
   end

   // classify the request, update node state and build the job
   always_comb begin
      joined_in     = joined_ff;
      has_parent_in = has_parent_ff;
      parent_in     = parent_ff;
      node_x_in     = node_x_ff;
      node_y_in     = node_y_ff;
      node_z_in     = node_z_ff;
      pend_in       = pend_ff;
      fc_in         = fc_ff;
      store_we      = 1'b0;
      job           = '0;
      q_push.push   = 1'b0;
      if (accept) begin
         case (req_cmd)
            flcm_pkg::CMD_START: begin
               if (is_master_ff) begin
                  joined_in     = 1'b1;
                  has_parent_in = 1'b0;
                  parent_in     = 3'd0;
                  node_x_in     = '0;
                  node_y_in     = '0;
                  node_z_in     = '0;
                  fc_in         = '0;
                  pend_in       = cnt_start;
                  job.fwd_mask  = nmask_ff;
                  job.ident     = own_id_ff;
                  if (cnt_start == 3'd0) begin
                     job.t1      = 1'b1;
                     job.t1_kind = flcm_pkg::K_DONE;
                  end
                  q_push.push = 1'b1;
               end
            end
            flcm_pkg::CMD_GO_MAP: begin
               if (port_ok) begin
                  if (!joined_ff) begin
                     joined_in     = 1'b1;
                     has_parent_in = 1'b1;
                     parent_in     = req_in_port;
                     node_x_in     = req_coord_x;
                     node_y_in     = req_coord_y;
                     node_z_in     = req_coord_z;
                     pend_in       = pend_ff + cnt_join;
                     job.fwd_mask  = fwd_join;
                     job.ident     = own_id_ff;
                     job.x         = req_coord_x;
                     job.y         = req_coord_y;
                     job.z         = req_coord_z;
                     // leaf: report straight back
                     if (pend_in == 3'd0) begin
                        job.t1 = 1'b1;
                        if (is_master_ff) begin
                           job.t1_kind = flcm_pkg::K_DONE;
                        end else begin
                           job.t1_kind    = flcm_pkg::K_FRAME;
                           job.t1_port    = req_in_port;
                           job.t1_use_id  = 1'b1;
                           job.t1_use_xyz = 1'b1;
                           job.t2         = 1'b1;
                        end
                     end
                  end else begin
                     // already mapped: close this branch
                     job.t1      = 1'b1;
                     job.t1_kind = flcm_pkg::K_END_MAP;
                     job.t1_port = req_in_port;
                  end
                  q_push.push = 1'b1;
               end
            end
            flcm_pkg::CMD_FRAME: begin
               if (port_ok && is_master_ff) begin
                  job.t1        = 1'b1;
                  job.t1_port   = req_in_port;
                  job.t1_use_id = 1'b1;
                  job.ident     = req_sender_id;
                  if (fc_ff < FCW'(FRAME_DEPTH)) begin
                     store_we    = 1'b1;
                     fc_in       = fc_ff + FCW'(1);
                     job.t1_kind = flcm_pkg::K_ACK;
                  end else begin
                     job.t1_kind = flcm_pkg::K_NACK;
                  end
                  q_push.push = 1'b1;
               end
            end
            flcm_pkg::CMD_END_MAP: begin
               if (port_ok && pend_ff != 3'd0) begin
                  pend_in = pend_ff - 3'd1;
                  if (pend_in == 3'd0) begin
                     if (is_master_ff) begin
                        job.t1      = 1'b1;
                        job.t1_kind = flcm_pkg::K_DONE;
                        q_push.push = 1'b1;
                     end else if (has_parent_ff) begin
                        job.t1         = 1'b1;
                        job.t1_kind    = flcm_pkg::K_FRAME;
                        job.t1_port    = parent_ff;
                        job.t1_use_id  = 1'b1;
                        job.t1_use_xyz = 1'b1;
                        job.t2         = 1'b1;
                        job.ident      = own_id_ff;
                        job.x          = node_x_ff;
                        job.y          = node_y_ff;
                        job.z          = node_z_ff;
                        q_push.push    = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      q_push.job = job;
   end

   // node state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         joined_ff     <= 1'b0;
         has_parent_ff <= 1'b0;
         parent_ff     <= 3'd0;
         node_x_ff     <= '0;
         node_y_ff     <= '0;
         node_z_ff     <= '0;
         pend_ff       <= 3'd0;
         fc_ff         <= '0;
      end else begin
         joined_ff     <= joined_in;
         has_parent_ff <= has_parent_in;
         parent_ff     <= parent_in;
         node_x_ff     <= node_x_in;
         node_y_ff     <= node_y_in;
         node_z_ff     <= node_z_in;
         pend_ff       <= pend_in;
         fc_ff         <= fc_in;
      end
   end

   // frame buffer write
   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_store[fc_ff[AW-1:0]] <= {req_coord_z, req_coord_y, req_coord_x, req_sender_id};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/flcm_queue.sv =====
`default_nettype none

module flcm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire flcm_pkg::push_type q_push,
   output logic                    q_full,
   output logic                    q_valid,
   output flcm_pkg::job_type       q_head,
   input  wire logic               q_pop
);

   localparam int DEPTH = flcm_pkg::JOB_QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   flcm_pkg::job_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign q_full  = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = slots_ff[rd_ptr_ff];
   assign do_push = q_push.push && !q_full;
   assign do_pop  = q_pop && q_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_push.job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/flcm_back.sv =====
`default_nettype none

module flcm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire flcm_pkg::job_type   q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_kind,
   output logic [2:0]               rsp_out_port,
   output logic [15:0]              rsp_msg_id,
   output logic signed [15:0]       rsp_msg_x,
   output logic signed [15:0]       rsp_msg_y,
   output logic signed [15:0]       rsp_msg_z,
   output logic                     rsp_last
);

   localparam int NP = flcm_pkg::NUM_PORTS;

   function automatic logic [2:0] low_port(input logic [NP-1:0] m);
      logic [2:0] r;
      r = 3'd0;
      for (int i = NP - 1; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat_inc(input logic signed [15:0] v);
      return (v == 16'sh7FFF) ? v : v + 16'sd1;
   endfunction

   function automatic logic signed [15:0] sat_dec(input logic signed [15:0] v);
      return (v == 16'sh8000) ? v : v - 16'sd1;
   endfunction

   // job in progress
   logic              cur_valid_ff, cur_valid_in;
   flcm_pkg::job_type cur_ff, cur_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          kind_ff, kind_in;
   logic [2:0]          port_ff, port_in;
   logic [15:0]         id_ff, id_in;
   logic signed [15:0]  x_ff, x_in;
   logic signed [15:0]  y_ff, y_in;
   logic signed [15:0]  z_ff, z_in;
   logic                last_ff, last_in;

   logic          adv;
   logic          emit;
   logic          has_go;
   logic [2:0]    gp;
   logic [NP-1:0] mask_rest;
   logic          load;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign emit      = cur_valid_ff && adv;
   assign has_go    = |cur_ff.fwd_mask;
   assign gp        = low_port(cur_ff.fwd_mask);
   assign mask_rest = cur_ff.fwd_mask & ~(NP'(1) << gp);

   // pick the next message of the current job
   always_comb begin
      cur_in       = cur_ff;
      kind_in      = kind_ff;
      port_in      = port_ff;
      id_in        = id_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (has_go) begin
            kind_in = flcm_pkg::K_GO_MAP;
            port_in = gp;
            id_in   = cur_ff.ident;
            x_in    = cur_ff.x;
            y_in    = cur_ff.y;
            z_in    = cur_ff.z;
            case (gp)
               3'd0:    z_in = sat_inc(cur_ff.z);
               3'd1:    z_in = sat_dec(cur_ff.z);
               3'd2:    x_in = sat_inc(cur_ff.x);
               3'd3:    x_in = sat_dec(cur_ff.x);
               3'd4:    y_in = sat_inc(cur_ff.y);
               default: y_in = sat_dec(cur_ff.y);
            endcase
            last_in         = (mask_rest == '0) && !cur_ff.t1 && !cur_ff.t2;
            cur_in.fwd_mask = mask_rest;
         end else if (cur_ff.t1) begin
            kind_in   = cur_ff.t1_kind;
            port_in   = cur_ff.t1_port;
            id_in     = cur_ff.t1_use_id ? cur_ff.ident : 16'd0;
            x_in      = cur_ff.t1_use_xyz ? cur_ff.x : 16'sd0;
            y_in      = cur_ff.t1_use_xyz ? cur_ff.y : 16'sd0;
            z_in      = cur_ff.t1_use_xyz ? cur_ff.z : 16'sd0;
            last_in   = !cur_ff.t2;
            cur_in.t1 = 1'b0;
         end else begin
            kind_in   = flcm_pkg::K_END_MAP;
            port_in   = cur_ff.t1_port;
            id_in     = 16'd0;
            x_in      = 16'sd0;
            y_in      = 16'sd0;
            z_in      = 16'sd0;
            last_in   = 1'b1;
            cur_in.t2 = 1'b0;
         end
      end
      // take the next job when none is current or as the current one finishes
      load         = q_valid && (!cur_valid_ff || (emit && last_in));
      cur_valid_in = emit ? !last_in : cur_valid_ff;
      if (load) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
      end
   end

   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      kind_ff <= kind_in;
      port_ff <= port_in;
      id_ff   <= id_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_port = port_ff;
   assign rsp_msg_id   = id_ff;
   assign rsp_msg_x    = x_ff;
   assign rsp_msg_y    = y_ff;
   assign rsp_msg_z    = z_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/flood_coordinate_mapping_node_core.sv =====
`default_nettype none

// One node of a six-port coordinate mapping wave. Each request (go-map,
// frame, end-map or start) is classified combinationally by the front
// end, which updates the node state at once and queues a job in a two-entry
// job queue; the back end then sends that job's messages one per cycle while
// rsp_ready is high, through a response register, last set on the final one.
// A request that causes n responses (1 to 6) holds the back end until all n
// are sent; a request with no response queues no job. Requests are still
// accepted while responses stall, until the job queue is full. Configuration
// is written through csr_we/csr_index/csr_wdata (0 is_master, 1 own_id,
// 2 neighbor_mask); the user must do so only while the node is idle, as the
// block does not enforce it. Received frames go into a FRAME_DEPTH entry buffer.
module flood_coordinate_mapping_node_core #(
   parameter int FRAME_DEPTH = flcm_pkg::FRAME_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [2:0]                      req_in_port,
   input  wire logic [15:0]                     req_sender_id,
   input  wire logic signed [15:0]              req_coord_x,
   input  wire logic signed [15:0]              req_coord_y,
   input  wire logic signed [15:0]              req_coord_z,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_kind,
   output logic [2:0]                           rsp_out_port,
   output logic [15:0]                          rsp_msg_id,
   output logic signed [15:0]                   rsp_msg_x,
   output logic signed [15:0]                   rsp_msg_y,
   output logic signed [15:0]                   rsp_msg_z,
   output logic                                 rsp_last,
   input  wire logic                            csr_we,
   input  wire logic [flcm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [flcm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   flcm_pkg::push_type q_push;
   flcm_pkg::job_type  q_head;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;

   // request decode and node state
   flcm_front #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_in_port   (req_in_port),
      .req_sender_id (req_sender_id),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .q_push        (q_push)
   );

   // job queue
   flcm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // message sender
   flcm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_port (rsp_out_port),
      .rsp_msg_id   (rsp_msg_id),
      .rsp_msg_x    (rsp_msg_x),
      .rsp_msg_y    (rsp_msg_y),
      .rsp_msg_z    (rsp_msg_z),
      .rsp_last     (rsp_last)
   );

   // queue is empty right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

   // a frame is always followed by its end-map
   a_frame_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == flcm_pkg::K_FRAME) |-> !rsp_last)
      else $error("frame response flagged last");

   // done closes the run and goes out on port zero
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == flcm_pkg::K_DONE) |-> (rsp_last && rsp_out_port == 3'd0))
      else $error("done response malformed");

   // a frame response is followed by end-map on the same port
   a_frame_then_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_kind == flcm_pkg::K_FRAME) |=>
      (rsp_valid && rsp_kind == flcm_pkg::K_END_MAP && rsp_out_port == $past(rsp_out_port)))
      else $error("end-map does not follow frame");

endmodule

`default_nettype wire

// ===== dv/tb_flood_coordinate_mapping_node_core.sv =====
module tb_flood_coordinate_mapping_node_core;

   localparam int DRAIN_CYCLES = 12;
   localparam int FINAL_SPIN   = 20000;
   localparam int ITEM_TARGET  = 280;

   // port numbers, same order as neighbor_mask
   localparam int PORT_TOP    = 0;
   localparam int PORT_BOTTOM = 1;
   localparam int PORT_RIGHT  = 2;
   localparam int PORT_LEFT   = 3;
   localparam int PORT_FRONT  = 4;

   // one outgoing message of the node
   typedef struct {
      logic [2:0]         kind;
      logic [2:0]         port;
      logic [15:0]        id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               last;
   } node_msg_type;

   // mirror of one mapping node: predicts the messages each request causes
   // and checks the node's responses against them in order
   class node_wave_mirror;
      bit                 is_master;
      logic [15:0]        own_id = '0;
      logic [5:0]         nbr_mask = '0;
      bit                 joined;
      bit                 has_parent;
      logic [2:0]         parent_port = '0;
      logic signed [15:0] node_x = '0;
      logic signed [15:0] node_y = '0;
      logic signed [15:0] node_z = '0;
      int                 pending_ends;
      int                 frame_count;
      node_msg_type       outgoing[$];
      int                 mismatches;
      int                 requests;
      int                 productive;
      int                 checked;
      int                 kind_tally[8];

      function void set_reg(logic [flcm_pkg::CSR_IDX_W-1:0] idx,
                            logic [flcm_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            flcm_pkg::CSR_IS_MASTER:     is_master = val[0];
            flcm_pkg::CSR_OWN_ID:        own_id = val;
            flcm_pkg::CSR_NEIGHBOR_MASK: nbr_mask = val[5:0];
            default: ;
         endcase
      endfunction

      function int waiting();
         return outgoing.size();
      endfunction

      // one step on an axis, saturating at the signed 16-bit limits
      function logic signed [15:0] nudge(logic signed [15:0] v, bit up);
         if (up) return (v == 16'sh7FFF) ? v : v + 16'sd1;
         return (v == 16'sh8000) ? v : v - 16'sd1;
      endfunction

      function void add_msg(logic [2:0] kind, logic [2:0] port, logic [15:0] id,
                            logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
         node_msg_type m;
         m.kind = kind;
         m.port = port;
         m.id   = id;
         m.x    = x;
         m.y    = y;
         m.z    = z;
         m.last = 1'b0;
         outgoing.push_back(m);
      endfunction

      // wave finished here: done on the master, frame and end-map upward otherwise
      function void complete();
         if (is_master) begin
            add_msg(flcm_pkg::K_DONE, 3'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0);
         end else if (has_parent) begin
            add_msg(flcm_pkg::K_FRAME, parent_port, own_id, node_x, node_y, node_z);
            add_msg(flcm_pkg::K_END_MAP, parent_port, 16'd0, 16'sd0, 16'sd0, 16'sd0);
         end
      endfunction

      // forward go-map on every connected port except the parent
      function void spread();
         for (int p = 0; p < flcm_pkg::NUM_PORTS; p++) begin
            logic signed [15:0] x, y, z;
            x = node_x;
            y = node_y;
            z = node_z;
            if (!nbr_mask[p]) continue;
            if (has_parent && p == parent_port) continue;
            case (p)
               PORT_TOP:    z = nudge(z, 1'b1);
               PORT_BOTTOM: z = nudge(z, 1'b0);
               PORT_RIGHT:  x = nudge(x, 1'b1);
               PORT_LEFT:   x = nudge(x, 1'b0);
               PORT_FRONT:  y = nudge(y, 1'b1);
               default:     y = nudge(y, 1'b0);
            endcase
            add_msg(flcm_pkg::K_GO_MAP, p[2:0], own_id, x, y, z);
            pending_ends++;
         end
         if (pending_ends == 0) complete();
      endfunction

      function void note_request(logic [1:0] cmd, logic [2:0] port, logic [15:0] sid,
                                 logic signed [15:0] cx, logic signed [15:0] cy,
                                 logic signed [15:0] cz);
         int prior_size;
         bit counted;
         prior_size = outgoing.size();
         counted    = 1'b0;
         requests++;
         if (cmd == flcm_pkg::CMD_START) begin
            if (is_master) begin
               joined       = 1'b1;
               has_parent   = 1'b0;
               parent_port  = 3'd0;
               node_x       = 16'sd0;
               node_y       = 16'sd0;
               node_z       = 16'sd0;
               pending_ends = 0;
               frame_count  = 0;
               spread();
            end
         end else if (port < flcm_pkg::NUM_PORTS && nbr_mask[port]) begin
            case (cmd)
               flcm_pkg::CMD_GO_MAP: begin
                  if (!joined) begin
                     joined      = 1'b1;
                     has_parent  = 1'b1;
                     parent_port = port;
                     node_x      = cx;
                     node_y      = cy;
                     node_z      = cz;
                     spread();
                  end else begin
                     add_msg(flcm_pkg::K_END_MAP, port, 16'd0, 16'sd0, 16'sd0, 16'sd0);
                  end
               end
               flcm_pkg::CMD_FRAME: begin
                  if (is_master) begin
                     if (frame_count < flcm_pkg::FRAME_DEPTH_DEF) begin
                        frame_count++;
                        add_msg(flcm_pkg::K_ACK, port, sid, 16'sd0, 16'sd0, 16'sd0);
                     end else begin
                        add_msg(flcm_pkg::K_NACK, port, sid, 16'sd0, 16'sd0, 16'sd0);
                     end
                  end
               end
               default: begin
                  if (pending_ends != 0) begin
                     pending_ends--;
                     counted = 1'b1;
                     if (pending_ends == 0) complete();
                  end
               end
            endcase
         end
         if (outgoing.size() > prior_size) begin
            outgoing[outgoing.size()-1].last = 1'b1;
            counted = 1'b1;
         end
         if (counted) productive++;
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_msg(node_msg_type got);
         node_msg_type want;
         checked++;
         kind_tally[got.kind]++;
         if (outgoing.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected, expected none, actual kind %0d port %0d",
                     $time, got.kind, got.port);
            return;
         end
         want = outgoing.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("out_port", want.port, got.port);
         compare_field("msg_id", want.id, got.id);
         compare_field("msg_x", want.x, got.x);
         compare_field("msg_y", want.y, got.y);
         compare_field("msg_z", want.z, got.z);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [1:0]                          req_cmd;
   logic [2:0]                          req_in_port;
   logic [15:0]                         req_sender_id;
   logic signed [15:0]                  req_coord_x;
   logic signed [15:0]                  req_coord_y;
   logic signed [15:0]                  req_coord_z;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [2:0]                          rsp_kind;
   logic [2:0]                          rsp_out_port;
   logic [15:0]                         rsp_msg_id;
   logic signed [15:0]                  rsp_msg_x;
   logic signed [15:0]                  rsp_msg_y;
   logic signed [15:0]                  rsp_msg_z;
   logic                                rsp_last;
   logic                                csr_we;
   logic [flcm_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [flcm_pkg::CSR_DATA_W-1:0]     csr_wdata;

   node_wave_mirror mirror = new();
   int sender_max_gap     = 16;
   int receiver_max_stall = 16;
   int phase_count        = 0;
   int config_count       = 0;

   flood_coordinate_mapping_node_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_in_port  (req_in_port),
      .req_sender_id(req_sender_id),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_coord_z  (req_coord_z),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_out_port (rsp_out_port),
      .rsp_msg_id   (rsp_msg_id),
      .rsp_msg_x    (rsp_msg_x),
      .rsp_msg_y    (rsp_msg_y),
      .rsp_msg_z    (rsp_msg_z),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      node_msg_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            mirror.note_request(req_cmd, req_in_port, req_sender_id,
                                req_coord_x, req_coord_y, req_coord_z);
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_kind;
            got.port = rsp_out_port;
            got.id   = rsp_msg_id;
            got.x    = rsp_msg_x;
            got.y    = rsp_msg_y;
            got.z    = rsp_msg_z;
            got.last = rsp_last;
            mirror.check_msg(got);
         end
      end
   end

   // response side: random stall before each response
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, receiver_max_stall);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // random word, biased toward the signed limits
   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h7FFE;
         3: return 16'h8001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_port(logic [5:0] mask);
      int p;
      if (mask == 6'd0) return 3'($urandom_range(0, 7));
      do p = $urandom_range(0, flcm_pkg::NUM_PORTS - 1); while (!mask[p]);
      return p[2:0];
   endfunction

   // one request; entered and left at a falling edge
   task automatic send(logic [1:0] cmd, logic [2:0] port, logic [15:0] sid,
                       logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_cmd       = cmd;
      req_in_port   = port;
      req_sender_id = sid;
      req_coord_x   = x;
      req_coord_y   = y;
      req_coord_z   = z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_rand(logic [1:0] cmd, logic [2:0] port);
      send(cmd, port, rand_word(), rand_word(), rand_word(), rand_word());
   endtask

   // wait until every predicted message has come out, then let the node drain
   task automatic settle();
      req_valid = 1'b0;
      while (mirror.waiting() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [flcm_pkg::CSR_IDX_W-1:0] idx,
                            logic [flcm_pkg::CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      mirror.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic configure(bit master, logic [15:0] id, logic [5:0] mask);
      settle();
      write_reg(flcm_pkg::CSR_IS_MASTER, {15'd0, master});
      write_reg(flcm_pkg::CSR_OWN_ID, id);
      write_reg(flcm_pkg::CSR_NEIGHBOR_MASK, {10'd0, mask});
      csr_we = 1'b0;
      config_count++;
   endtask

   // one random wave: configure, start, then replies, frames and noise
   task automatic run_phase();
      bit          master, heavy;
      logic [15:0] id;
      logic [5:0]  mask;
      int          flooded, ends_left, body, r;
      phase_count++;
      heavy              = (phase_count % 3 == 1);
      sender_max_gap     = (phase_count % 4 == 3) ? 0 : 16;
      receiver_max_stall = (phase_count % 5 == 4) ? 0 : 16;
      master             = heavy || ($urandom_range(0, 5) != 0);
      case (phase_count % 7)
         0: mask = 6'h3F;
         3: mask = 6'h00;
         default: mask = 6'($urandom_range(0, 63));
      endcase
      if (heavy && mask == 6'h00) mask = 6'h21;
      case (phase_count % 5)
         0: id = 16'hFFFF;
         2: id = 16'h0000;
         default: id = 16'($urandom);
      endcase
      configure(master, id, mask);
      flooded = $countones(mask);
      send_rand(flcm_pkg::CMD_START, pick_port(mask));
      ends_left = master ? flooded : 0;
      body = heavy ? 24 : $urandom_range(8, 16);
      for (int i = 0; i < body; i++) begin
         r = $urandom_range(0, 99);
         if (heavy) begin
            // enough frames to fill the buffer and overflow it
            if (ends_left > 0 && r < 20) begin
               send_rand(flcm_pkg::CMD_END_MAP, pick_port(mask));
               ends_left--;
            end else begin
               send_rand(flcm_pkg::CMD_FRAME, pick_port(mask));
            end
         end else if (ends_left > 0 && r < 35) begin
            send_rand(flcm_pkg::CMD_END_MAP, pick_port(mask));
            ends_left--;
         end else if (r < 60) begin
            send_rand(flcm_pkg::CMD_FRAME, pick_port(mask));
         end else if (r < 75) begin
            send_rand(flcm_pkg::CMD_GO_MAP, pick_port(mask));
         end else if (r < 83) begin
            send_rand(flcm_pkg::CMD_START, pick_port(mask));
            ends_left = master ? flooded : 0;
         end else begin
            send_rand(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)));
         end
      end
      while (ends_left > 0) begin
         send_rand(flcm_pkg::CMD_END_MAP, pick_port(mask));
         ends_left--;
      end
   endtask

   initial begin
      int spin;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = flcm_pkg::CMD_GO_MAP;
      req_in_port   = 3'd0;
      req_sender_id = 16'd0;
      req_coord_x   = 16'sd0;
      req_coord_y   = 16'sd0;
      req_coord_z   = 16'sd0;
      csr_we        = 1'b0;
      csr_index     = flcm_pkg::CSR_IS_MASTER;
      csr_wdata     = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // nothing connected, not master: everything is ignored
      send_rand(flcm_pkg::CMD_GO_MAP, 3'd0);
      send_rand(flcm_pkg::CMD_FRAME, 3'd5);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd2);
      send_rand(flcm_pkg::CMD_START, 3'd0);

      // master joined by go-map before any start, coordinates at the limits
      configure(1'b1, 16'hFFFF, 6'h3F);
      send(flcm_pkg::CMD_GO_MAP, 3'd3, 16'h1234, 16'h7FFF, 16'h8000, 16'h7FFF);

      // finish the wave as a non-master: frame and end-map to the parent
      configure(1'b0, 16'h0000, 6'h3F);
      send_rand(flcm_pkg::CMD_GO_MAP, 3'd6);
      send_rand(flcm_pkg::CMD_GO_MAP, 3'd7);
      send_rand(flcm_pkg::CMD_GO_MAP, 3'd1);
      send_rand(flcm_pkg::CMD_FRAME, 3'd2);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd0);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd1);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd2);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd4);
      send_rand(flcm_pkg::CMD_START, 3'd0);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd5);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd0);

      // start with no port to forward on reports done at once
      configure(1'b1, 16'h5A3C, 6'h00);
      send_rand(flcm_pkg::CMD_START, 3'd0);
      send_rand(flcm_pkg::CMD_GO_MAP, 3'd0);

      // single port, restarted wave, one frame, surplus end-map
      configure(1'b1, 16'h5A3C, 6'h01);
      send_rand(flcm_pkg::CMD_START, 3'd0);
      send_rand(flcm_pkg::CMD_START, 3'd0);
      send(flcm_pkg::CMD_FRAME, 3'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd0);
      send_rand(flcm_pkg::CMD_END_MAP, 3'd0);

      // random waves
      while (mirror.requests < ITEM_TARGET) run_phase();

      // drain
      req_valid = 1'b0;
      spin = 0;
      while (mirror.waiting() != 0 && spin < FINAL_SPIN) begin
         @(negedge clock);
         spin++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mirror.waiting() != 0) begin
         $display("%0t: %0d expected messages never came out", $time, mirror.waiting());
         mirror.mismatches++;
      end

      $display("Covered %0d requests (%0d with effect) over %0d settings, %0d messages checked",
               mirror.requests, mirror.productive, config_count, mirror.checked);
      $display("go-map %0d, frame %0d, end-map %0d, ack %0d, nack %0d, done %0d",
               mirror.kind_tally[flcm_pkg::K_GO_MAP], mirror.kind_tally[flcm_pkg::K_FRAME],
               mirror.kind_tally[flcm_pkg::K_END_MAP], mirror.kind_tally[flcm_pkg::K_ACK],
               mirror.kind_tally[flcm_pkg::K_NACK], mirror.kind_tally[flcm_pkg::K_DONE]);
      if (mirror.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
